[src/page_frame_allocator_unit_macros.svh]
`ifndef PAGE_FRAME_ALLOCATOR_UNIT_MACROS_SVH
`define PAGE_FRAME_ALLOCATOR_UNIT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define PFA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define PFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m failed");
`endif

[src/pfa_pkg.sv]
package pfa_pkg;
    localparam int PAGE_BITS_DEF   = 22;
    localparam int FREE_RANGES_DEF = 1024;
    localparam int HELD_DEPTH_DEF  = 4096;
    localparam int MAX_COUNT_DEF   = 64;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FEW_PAGES = 2'd1,
        ST_HELD_FULL = 2'd2,
        ST_STORE_FULL = 2'd3
    } status_t;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;
    localparam logic CFG_POOL_START = 1'b0;
    localparam logic CFG_POOL_END   = 1'b1;
endpackage

[src/pfa_ram.sv]
module pfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[src/page_frame_allocator_unit.sv]
// Page-frame allocator. Free pages are kept as a FIFO of ranges [first,
// limit) in two RAMs and allocated pages in a FIFO RAM. One transaction is
// handled at a time and in_stall is high while it runs and while its last
// result waits to be taken. After acceptance an allocate transaction runs
// its checks and then, per page, a range read, a page issue and a result
// handover; the range read of a page waits while the result of the previous
// page is still stalled. Errors and zero counts offer their single result
// straight after the checks. A release transaction runs a setup step, a
// held read and a range append per page, and a last read before its summary
// result. The rate is set by the shared sequencer, which performs one RAM
// read and one update per page. Writing either pool register (the user must
// do so only while idle; the block does not enforce it) resets both FIFOs
// at once; the RAMs hold no reset, and the first cycle after reset writes
// the reset pool range into the range RAMs, with in_stall high.
module page_frame_allocator_unit #(
    parameter int PAGE_BITS   = pfa_pkg::PAGE_BITS_DEF,
    parameter int FREE_RANGES = pfa_pkg::FREE_RANGES_DEF,
    parameter int HELD_DEPTH  = pfa_pkg::HELD_DEPTH_DEF,
    parameter int MAX_COUNT   = pfa_pkg::MAX_COUNT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [PAGE_BITS:0]            cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          cmd,
    input  logic [pfa_pkg::COUNT_W-1:0]   count,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [PAGE_BITS-1:0]          page,
    output logic [pfa_pkg::STATUS_W-1:0]  status,
    output logic                          last,
    output logic [pfa_pkg::COUNT_W-1:0]   moved,
    output logic [PAGE_BITS:0]            free_pages,
    output logic [$clog2(HELD_DEPTH+1)-1:0] active_pages
);
    localparam int RW = $clog2(FREE_RANGES);
    localparam int RCW = $clog2(FREE_RANGES + 1);
    localparam int HW = $clog2(HELD_DEPTH);
    localparam int HCW = $clog2(HELD_DEPTH + 1);
    localparam int TW = PAGE_BITS + 1;
    localparam logic [TW-1:0] SPAN = TW'(1) << PAGE_BITS;
    localparam logic [RW-1:0] R_LAST = RW'(FREE_RANGES - 1);
    localparam logic [HW-1:0] H_LAST = HW'(HELD_DEPTH - 1);

    // One-hot sequencer states.
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CHECK = 7'b0000010,
        S_AREAD = 7'b0000100,
        S_AISS  = 7'b0001000,
        S_RREAD = 7'b0010000,
        S_RMOVE = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [PAGE_BITS-1:0] pool_start_reg;
    logic [TW-1:0]        pool_end_reg;
    logic [RW-1:0]  rhead_reg, rtail_reg;
    logic [RCW-1:0] rcount_reg;
    logic [TW-1:0]  free_reg;
    logic [HW-1:0]  hhead_reg, htail_reg;
    logic [HCW-1:0] hcount_reg;
    logic           cmd_reg;
    logic [pfa_pkg::COUNT_W-1:0] left_reg, moved_reg;
    logic           more_reg;
    logic           init_reg;

    logic [PAGE_BITS-1:0] page_reg;
    logic [1:0]     status_reg;
    logic           last_reg, ovalid_reg;

    // Range RAMs: one write port shared by the pool range write, the allocate
    // update and the release append.
    logic                 r_we;
    logic [RW-1:0]        r_waddr;
    logic [PAGE_BITS-1:0] rf_wdata, rf_rdata;
    logic [TW-1:0]        rl_wdata, rl_rdata;
    logic                 h_we;
    logic [PAGE_BITS-1:0] h_rdata;

    pfa_ram #(.WIDTH(PAGE_BITS), .DEPTH(FREE_RANGES)) u_first (
        .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(rf_wdata),
        .raddr(rhead_reg), .rdata(rf_rdata));
    pfa_ram #(.WIDTH(TW), .DEPTH(FREE_RANGES)) u_limit (
        .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(rl_wdata),
        .raddr(rhead_reg), .rdata(rl_rdata));
    pfa_ram #(.WIDTH(PAGE_BITS), .DEPTH(HELD_DEPTH)) u_held (
        .clk(clk), .we(h_we), .waddr(htail_reg), .wdata(rf_rdata),
        .raddr(hhead_reg), .rdata(h_rdata));

    logic [PAGE_BITS:0] next_first;
    logic [TW-1:0]      cfg_end_sat;
    logic [pfa_pkg::COUNT_W-1:0] cnt_sat;
    logic               cfg_write;
    logic [PAGE_BITS-1:0] new_start;
    logic [TW-1:0]        new_end;

    assign next_first = {1'b0, rf_rdata} + 1'b1;
    assign cfg_end_sat = (cfg_data > SPAN) ? SPAN : cfg_data;
    assign cnt_sat = (count > pfa_pkg::COUNT_W'(MAX_COUNT))
                   ? pfa_pkg::COUNT_W'(MAX_COUNT) : count;
    assign in_stall = (state_reg != S_IDLE) || ovalid_reg || init_reg;
    assign cfg_write = cfg_we;
    assign new_start = (cfg_write && cfg_index == pfa_pkg::CFG_POOL_START)
                     ? cfg_data[PAGE_BITS-1:0] : pool_start_reg;
    assign new_end = (cfg_write && cfg_index == pfa_pkg::CFG_POOL_END)
                   ? cfg_end_sat : pool_end_reg;

    always_comb
    begin
        r_we     = 1'b0;
        r_waddr  = rhead_reg;
        rf_wdata = next_first[PAGE_BITS-1:0];
        rl_wdata = rl_rdata;
        h_we     = 1'b0;
        // A register write, and the first cycle after reset, store the pool
        // range in entry zero.
        if (cfg_write || init_reg)
        begin
            r_we     = 1'b1;
            r_waddr  = '0;
            rf_wdata = new_start;
            rl_wdata = new_end;
        end
        else if (state_reg == S_AISS)
        begin
            r_we = 1'b1;
            h_we = 1'b1;
        end
        else if (state_reg == S_RMOVE)
        begin
            r_we     = 1'b1;
            r_waddr  = rtail_reg;
            rf_wdata = h_rdata;
            rl_wdata = {1'b0, h_rdata} + 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_valid && !in_stall) state_next = S_CHECK;
            S_CHECK:
            begin
                if (cmd_reg == pfa_pkg::CMD_RELEASE)
                    state_next = S_RREAD;
                else if (left_reg == '0 || TW'(left_reg) > free_reg
                         || int'(hcount_reg) + int'(left_reg) > HELD_DEPTH)
                    state_next = S_OUT;
                else
                    state_next = S_AREAD;
            end
            // The next page is issued only once the previous one is taken.
            S_AREAD: if (!ovalid_reg || !out_stall) state_next = S_AISS;
            S_AISS:  state_next = S_OUT;
            S_RREAD:
            begin
                if (left_reg == '0 || hcount_reg == '0
                    || rcount_reg >= RCW'(FREE_RANGES))
                    state_next = S_OUT;
                else
                    state_next = S_RMOVE;
            end
            S_RMOVE: state_next = S_RREAD;
            S_OUT:
            begin
                if (!ovalid_reg || !out_stall)
                    state_next = more_reg ? S_AREAD : S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pool_start_reg <= '0;
            pool_end_reg   <= SPAN;
            rhead_reg      <= '0;
            rtail_reg      <= RW'(1 % FREE_RANGES);
            rcount_reg     <= RCW'(1);
            free_reg       <= SPAN;
            hhead_reg      <= '0;
            htail_reg      <= '0;
            hcount_reg     <= '0;
            ovalid_reg     <= 1'b0;
            more_reg       <= 1'b0;
            init_reg       <= 1'b1;
            cmd_reg        <= pfa_pkg::CMD_ALLOC;
            left_reg       <= '0;
            moved_reg      <= '0;
            page_reg       <= '0;
            status_reg     <= pfa_pkg::ST_OK;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            init_reg  <= 1'b0;
            if (state_reg == S_OUT && (!ovalid_reg || !out_stall))
                ovalid_reg <= 1'b1;
            else if (ovalid_reg && !out_stall)
                ovalid_reg <= 1'b0;
            if (cfg_write)
            begin
                pool_start_reg <= new_start;
                pool_end_reg   <= new_end;
                rhead_reg  <= '0;
                hhead_reg  <= '0;
                htail_reg  <= '0;
                hcount_reg <= '0;
                if (new_end > TW'(new_start))
                begin
                    rtail_reg  <= RW'(1 % FREE_RANGES);
                    rcount_reg <= RCW'(1);
                    free_reg   <= new_end - TW'(new_start);
                end
                else
                begin
                    rtail_reg  <= '0;
                    rcount_reg <= '0;
                    free_reg   <= '0;
                end
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && !in_stall)
                    begin
                        cmd_reg   <= cmd;
                        left_reg  <= cnt_sat;
                        moved_reg <= '0;
                    end
                end
                S_CHECK:
                begin
                    if (cmd_reg == pfa_pkg::CMD_ALLOC && state_next == S_OUT)
                    begin
                        page_reg <= '0;
                        last_reg <= 1'b1;
                        more_reg <= 1'b0;
                        if (left_reg == '0)
                            status_reg <= pfa_pkg::ST_OK;
                        else if (TW'(left_reg) > free_reg)
                            status_reg <= pfa_pkg::ST_FEW_PAGES;
                        else
                            status_reg <= pfa_pkg::ST_HELD_FULL;
                    end
                end
                S_AREAD: ;
                S_AISS:
                begin
                    page_reg   <= rf_rdata;
                    status_reg <= pfa_pkg::ST_OK;
                    if (next_first >= rl_rdata)
                    begin
                        rhead_reg  <= (rhead_reg == R_LAST) ? '0 : rhead_reg + 1'b1;
                        rcount_reg <= rcount_reg - 1'b1;
                    end
                    free_reg   <= free_reg - 1'b1;
                    htail_reg  <= (htail_reg == H_LAST) ? '0 : htail_reg + 1'b1;
                    hcount_reg <= hcount_reg + 1'b1;
                    left_reg   <= left_reg - 1'b1;
                    // Free count was checked, so ranges never run out early.
                    last_reg   <= (left_reg == pfa_pkg::COUNT_W'(1));
                    more_reg   <= (left_reg != pfa_pkg::COUNT_W'(1));
                end
                S_RREAD:
                begin
                    if (state_next == S_OUT)
                    begin
                        page_reg   <= '0;
                        last_reg   <= 1'b1;
                        more_reg   <= 1'b0;
                        status_reg <= (left_reg != '0 && hcount_reg != '0)
                                    ? pfa_pkg::ST_STORE_FULL : pfa_pkg::ST_OK;
                    end
                end
                S_RMOVE:
                begin
                    hhead_reg  <= (hhead_reg == H_LAST) ? '0 : hhead_reg + 1'b1;
                    hcount_reg <= hcount_reg - 1'b1;
                    rtail_reg  <= (rtail_reg == R_LAST) ? '0 : rtail_reg + 1'b1;
                    rcount_reg <= rcount_reg + 1'b1;
                    free_reg   <= free_reg + 1'b1;
                    moved_reg  <= moved_reg + 1'b1;
                    left_reg   <= left_reg - 1'b1;
                end
                S_OUT: ;
                default: ;
            endcase
        end
    end

    // Totals of an allocate item are final only after its last page, so
    // the output registers for them are loaded from the precomputed end
    // values: free and held counts change by the full count once checks pass.
    logic [TW-1:0]  free_out_reg;
    logic [HCW-1:0] held_out_reg;
    logic [pfa_pkg::COUNT_W-1:0] moved_out_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CHECK)
        begin
            if (cmd_reg == pfa_pkg::CMD_ALLOC && state_next == S_AREAD)
            begin
                free_out_reg <= free_reg - TW'(left_reg);
                held_out_reg <= hcount_reg + HCW'(left_reg);
            end
            else
            begin
                free_out_reg <= free_reg;
                held_out_reg <= hcount_reg;
            end
            moved_out_reg <= '0;
        end
        else if (state_reg == S_RREAD && state_next == S_OUT)
        begin
            free_out_reg  <= free_reg;
            held_out_reg  <= hcount_reg;
            moved_out_reg <= moved_reg;
        end
    end

    assign out_valid    = ovalid_reg;
    assign page         = page_reg;
    assign status       = status_reg;
    assign last         = last_reg;
    assign moved        = moved_out_reg;
    assign free_pages   = free_out_reg;
    assign active_pages = held_out_reg;
endmodule

[src/pfa_checker.sv]
`include "page_frame_allocator_unit_macros.svh"
module pfa_checker #(
    parameter int PAGE_BITS  = pfa_pkg::PAGE_BITS_DEF,
    parameter int HELD_DEPTH = pfa_pkg::HELD_DEPTH_DEF
) (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic [PAGE_BITS-1:0] page,
    input logic [pfa_pkg::STATUS_W-1:0] status,
    input logic last,
    input logic [$clog2(HELD_DEPTH+1)-1:0] active_pages
);
    localparam int HCW = $clog2(HELD_DEPTH + 1);

    // A result waiting to be taken keeps its page and last flag.
    `PFA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(page) && $stable(last))
    // Error results are single and carry no page.
    `PFA_ASSERT_IMP(a_err_last, clk, rst_n, out_valid && status != pfa_pkg::ST_OK, last && page == '0)
    // The held count never exceeds the FIFO depth.
    `PFA_ASSERT_IMP(a_held_max, clk, rst_n, out_valid, active_pages <= HCW'(HELD_DEPTH))
    // No new transaction is taken while a result waits.
    `PFA_ASSERT_IMP(a_busy, clk, rst_n, in_valid && out_valid, in_stall)
endmodule

bind page_frame_allocator_unit pfa_checker #(.PAGE_BITS(PAGE_BITS), .HELD_DEPTH(HELD_DEPTH)) u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .page(page), .status(status),
    .last(last), .active_pages(active_pages));

[dv/page_frame_allocator_unit_tb.sv]
`timescale 1ns / 1ps

module page_frame_allocator_unit_tb;
    localparam int PB        = pfa_pkg::PAGE_BITS_DEF;
    localparam int NRANGES   = pfa_pkg::FREE_RANGES_DEF;
    localparam int NHELD     = pfa_pkg::HELD_DEPTH_DEF;
    localparam int CMAX      = pfa_pkg::MAX_COUNT_DEF;
    localparam int CW        = pfa_pkg::COUNT_W;
    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE     = 40;

    typedef struct {
        logic [PB-1:0]      page;
        pfa_pkg::status_t   status;
        logic               last;
        logic [CW-1:0]      moved;
        logic [PB:0]        free_pages;
        logic [12:0]        active_pages;
    } grant_t;

    typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic               index;
        logic [PB:0]        data;
        logic               op;
        logic [CW-1:0]      cnt;
        logic               typed;
        logic [PB-1:0]      typed_page;
        pfa_pkg::status_t   typed_status;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic               cfg_index;
    logic [PB:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic               cmd;
    logic [CW-1:0]      count;
    logic               out_valid;
    logic               out_stall;
    logic [PB-1:0]      page;
    logic [1:0]         status;
    logic               last;
    logic [CW-1:0]      moved;
    logic [PB:0]        free_pages;
    logic [12:0]        active_pages;

    page_frame_allocator_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .count        (count),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .page         (page),
        .status       (status),
        .last         (last),
        .moved        (moved),
        .free_pages   (free_pages),
        .active_pages (active_pages)
    );

    // Predictor state: the pool registers, the ring of free ranges and the
    // ring of pages currently handed out.
    logic [PB-1:0] pool_first;
    logic [PB:0]   pool_limit;
    logic [PB-1:0] range_lo [NRANGES];
    logic [PB:0]   range_hi [NRANGES];
    int            rng_head, rng_tail, rng_count;
    logic [PB:0]   free_count;
    logic [PB-1:0] held_ring [NHELD];
    int            held_rd, held_wr, held_count;

    grant_t pending_grants[$];
    row_t   stimulus_table[$];

    int mismatches;
    int items_sent;
    int grants_seen;
    int status_seen [4];
    int idle_cycles;
    int burst_left;
    int stall_mode;
    int stall_timer;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // The free store is reset to the single range that the pool registers
    // describe, and the held FIFO is emptied. An empty pool leaves no range.
    task automatic rebuild_pool();
        rng_head   = 0;
        held_rd    = 0;
        held_wr    = 0;
        held_count = 0;
        if (pool_limit > {1'b0, pool_first})
        begin
            range_lo[0] = pool_first;
            range_hi[0] = pool_limit;
            rng_tail    = 1;
            rng_count   = 1;
            free_count  = pool_limit - {1'b0, pool_first};
        end
        else
        begin
            rng_tail   = 0;
            rng_count  = 0;
            free_count = '0;
        end
    endtask

    task automatic note_register(input logic idx, input logic [PB:0] value);
        if (idx == pfa_pkg::CFG_POOL_START)
            pool_first = value[PB-1:0];
        else
            pool_limit = (value > (1 << PB)) ? (PB+1)'(1 << PB) : value;
        rebuild_pool();
    endtask

    task automatic queue_grant(input logic [PB-1:0] pg, input pfa_pkg::status_t st,
                               input logic lst, input logic [CW-1:0] mv);
        grant_t g;
        g.page         = pg;
        g.status       = st;
        g.last         = lst;
        g.moved        = mv;
        g.free_pages   = free_count;
        g.active_pages = 13'(held_count);
        pending_grants = {pending_grants, g};
    endtask

    // Works out every result that one accepted request causes and queues them.
    task automatic forecast_request(input logic op, input logic [CW-1:0] cnt);
        int               n;
        int               taken;
        int               released;
        pfa_pkg::status_t st;
        logic [PB-1:0]    pages [CMAX];
        n = (cnt > CMAX) ? CMAX : int'(cnt);
        if (op == pfa_pkg::CMD_ALLOC)
        begin
            if (n == 0)
                queue_grant('0, pfa_pkg::ST_OK, 1'b1, '0);
            else if (n > free_count)
                queue_grant('0, pfa_pkg::ST_FEW_PAGES, 1'b1, '0);
            else if (held_count + n > NHELD)
                queue_grant('0, pfa_pkg::ST_HELD_FULL, 1'b1, '0);
            else
            begin
                taken = 0;
                while (taken < n && rng_count > 0)
                begin
                    pages[taken] = range_lo[rng_head];
                    range_lo[rng_head] = range_lo[rng_head] + 1'b1;
                    if ({1'b0, range_lo[rng_head]} >= range_hi[rng_head]
                        || range_lo[rng_head] == '0)
                    begin
                        rng_head  = (rng_head + 1) % NRANGES;
                        rng_count = rng_count - 1;
                    end
                    free_count = free_count - 1'b1;
                    held_ring[held_wr] = pages[taken];
                    held_wr    = (held_wr + 1) % NHELD;
                    held_count = held_count + 1;
                    taken      = taken + 1;
                end
                // The totals carried on each page are those after the whole request.
                for (int k = 0; k < taken; k++)
                    queue_grant(pages[k], pfa_pkg::ST_OK, k == taken - 1, '0);
            end
        end
        else
        begin
            released = 0;
            st       = pfa_pkg::ST_OK;
            while (released < n && held_count > 0)
            begin
                if (rng_count >= NRANGES)
                begin
                    st = pfa_pkg::ST_STORE_FULL;
                    break;
                end
                range_lo[rng_tail] = held_ring[held_rd];
                range_hi[rng_tail] = {1'b0, held_ring[held_rd]} + 1'b1;
                held_rd    = (held_rd + 1) % NHELD;
                held_count = held_count - 1;
                rng_tail   = (rng_tail + 1) % NRANGES;
                rng_count  = rng_count + 1;
                free_count = free_count + 1'b1;
                released   = released + 1;
            end
            queue_grant('0, st, 1'b1, CW'(released));
        end
    endtask

    // The range wrap check above covers a range that ends exactly at the top
    // of the page space, where the incremented start wraps to zero.

    task automatic wait_until_drained();
        in_valid <= 1'b0;
        while (pending_grants.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [PB:0] value);
        wait_until_drained();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        note_register(idx, value);
    endtask

    // Sends one request. The sender works in bursts; between bursts it may drop
    // valid for a random number of cycles. Acceptance is judged on the falling
    // edge, where the stall is stable up to the next rising edge.
    task automatic send_request(input logic op, input logic [CW-1:0] cnt,
                                output int first_slot);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 14);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left = burst_left - 1;
        in_valid <= 1'b1;
        cmd      <= op;
        count    <= cnt;
        forever
        begin
            @(negedge clk);
            if (!in_stall)
                break;
        end
        @(posedge clk);
        first_slot = pending_grants.size();
        forecast_request(op, cnt);
        items_sent = items_sent + 1;
    endtask

    task automatic add_cfg(input logic idx, input logic [PB:0] value);
        row_t r;
        r.kind         = ROW_CFG;
        r.index        = idx;
        r.data         = value;
        r.op           = pfa_pkg::CMD_ALLOC;
        r.cnt          = '0;
        r.typed        = 1'b0;
        r.typed_page   = '0;
        r.typed_status = pfa_pkg::ST_OK;
        stimulus_table = {stimulus_table, r};
    endtask

    task automatic add_item(input logic op, input logic [CW-1:0] cnt,
                            input logic typed, input logic [PB-1:0] pg,
                            input pfa_pkg::status_t st);
        row_t r;
        r.kind         = ROW_ITEM;
        r.index        = pfa_pkg::CFG_POOL_START;
        r.data         = '0;
        r.op           = op;
        r.cnt          = cnt;
        r.typed        = typed;
        r.typed_page   = pg;
        r.typed_status = st;
        stimulus_table = {stimulus_table, r};
    endtask

    // Random counts favour requests of one to four pages, but still
    // reach the saturating range above the maximum count.
    function automatic logic [CW-1:0] pick_alloc_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return CW'($urandom_range(1, 4));
        else if (r < 85)
            return CW'($urandom_range(0, 16));
        else if (r < 95)
            return CW'($urandom_range(17, CMAX));
        else
            return CW'($urandom_range(CMAX + 1, 127));
    endfunction

    // Receiver back-pressure: the mode is re-drawn whenever its random timer runs out and
    // includes stretches with no stall at all.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall   <= 1'b0;
            stall_mode  <= 0;
            stall_timer <= 0;
        end
        else
        begin
            if (stall_timer == 0)
            begin
                stall_mode  <= $urandom_range(0, 3);
                stall_timer <= $urandom_range(50, 300);
            end
            else
                stall_timer <= stall_timer - 1;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 9) < 3);
                2: out_stall <= (stall_timer % 5) < 2;
                default: out_stall <= ($urandom_range(0, 9) < 7);
            endcase
        end
    end

    // Result checking against the oldest queued expectation.
    always @(negedge clk)
    begin
        grant_t g;
        if (rst_n && out_valid && !out_stall)
        begin
            grants_seen = grants_seen + 1;
            status_seen[status] = status_seen[status] + 1;
            if (pending_grants.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("ERROR: result with nothing expected, page %0d status %0d",
                             page, status);
            end
            else
            begin
                g = pending_grants.pop_front();
                if (page !== g.page || status !== g.status || last !== g.last
                    || moved !== g.moved || free_pages !== g.free_pages
                    || active_pages !== g.active_pages)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                    begin
                        $display("ERROR: expected page %0d status %0d last %0b moved %0d free %0d active %0d",
                                 g.page, g.status, g.last, g.moved, g.free_pages,
                                 g.active_pages);
                        $display("       got      page %0d status %0d last %0b moved %0d free %0d active %0d",
                                 page, status, last, moved, free_pages, active_pages);
                    end
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither channel completes a transaction.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("ERROR: no transaction for %0d cycles", IDLE_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        int  slot;
        int  phase_items;
        int  pool_size;
        logic [PB:0] lo;
        cfg_we      = 1'b0;
        cfg_index   = pfa_pkg::CFG_POOL_START;
        cfg_data    = '0;
        in_valid    = 1'b0;
        cmd         = pfa_pkg::CMD_ALLOC;
        count       = '0;
        mismatches  = 0;
        items_sent  = 0;
        grants_seen = 0;
        idle_cycles = 0;
        burst_left  = 0;
        status_seen = '{default: 0};
        pool_first  = '0;
        pool_limit  = (PB+1)'(1 << PB);
        rebuild_pool();

        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. After reset the pool starts at page zero.
        add_item(pfa_pkg::CMD_ALLOC, 7'd0, 1'b1, '0, pfa_pkg::ST_OK);
        add_item(pfa_pkg::CMD_ALLOC, 7'd1, 1'b1, '0, pfa_pkg::ST_OK);
        add_item(pfa_pkg::CMD_ALLOC, 7'd127, 1'b0, '0, pfa_pkg::ST_OK);
        add_item(pfa_pkg::CMD_ALLOC, 7'd64, 1'b0, '0, pfa_pkg::ST_OK);
        add_item(pfa_pkg::CMD_RELEASE, 7'd0, 1'b1, '0, pfa_pkg::ST_OK);
        add_item(pfa_pkg::CMD_RELEASE, 7'd1, 1'b1, '0, pfa_pkg::ST_OK);
        add_item(pfa_pkg::CMD_RELEASE, 7'd127, 1'b0, '0, pfa_pkg::ST_OK);
        add_item(pfa_pkg::CMD_RELEASE, 7'd100, 1'b1, '0, pfa_pkg::ST_OK);
        add_item(pfa_pkg::CMD_ALLOC, 7'd3, 1'b0, '0, pfa_pkg::ST_OK);
        // A three-page pool: too few pages, then a short release.
        add_cfg(pfa_pkg::CFG_POOL_START, 23'd100);
        add_cfg(pfa_pkg::CFG_POOL_END, 23'd103);
        add_item(pfa_pkg::CMD_ALLOC, 7'd4, 1'b1, '0, pfa_pkg::ST_FEW_PAGES);
        add_item(pfa_pkg::CMD_ALLOC, 7'd2, 1'b1, 22'd100, pfa_pkg::ST_OK);
        add_item(pfa_pkg::CMD_ALLOC, 7'd2, 1'b1, '0, pfa_pkg::ST_FEW_PAGES);
        add_item(pfa_pkg::CMD_RELEASE, 7'd5, 1'b1, '0, pfa_pkg::ST_OK);
        add_item(pfa_pkg::CMD_ALLOC, 7'd3, 1'b0, '0, pfa_pkg::ST_OK);
        // Empty pool.
        add_cfg(pfa_pkg::CFG_POOL_START, 23'd50);
        add_cfg(pfa_pkg::CFG_POOL_END, 23'd50);
        add_item(pfa_pkg::CMD_ALLOC, 7'd1, 1'b1, '0, pfa_pkg::ST_FEW_PAGES);
        add_item(pfa_pkg::CMD_RELEASE, 7'd5, 1'b1, '0, pfa_pkg::ST_OK);
        // Oversized pool end saturates; the pool is the very top page.
        add_cfg(pfa_pkg::CFG_POOL_END, 23'h7FFFFF);
        add_cfg(pfa_pkg::CFG_POOL_START, 23'h3FFFFF);
        add_item(pfa_pkg::CMD_ALLOC, 7'd1, 1'b1, 22'h3FFFFF, pfa_pkg::ST_OK);
        add_item(pfa_pkg::CMD_ALLOC, 7'd1, 1'b1, '0, pfa_pkg::ST_FEW_PAGES);
        add_item(pfa_pkg::CMD_RELEASE, 7'd1, 1'b1, '0, pfa_pkg::ST_OK);
        add_item(pfa_pkg::CMD_ALLOC, 7'd1, 1'b1, 22'h3FFFFF, pfa_pkg::ST_OK);

        foreach (stimulus_table[i])
        begin
            if (stimulus_table[i].kind == ROW_CFG)
                write_register(stimulus_table[i].index, stimulus_table[i].data);
            else
            begin
                send_request(stimulus_table[i].op, stimulus_table[i].cnt, slot);
                if (stimulus_table[i].typed)
                begin
                    pending_grants[slot].page   = stimulus_table[i].typed_page;
                    pending_grants[slot].status = stimulus_table[i].typed_status;
                end
            end
        end

        // Stress pass: fill the held FIFO, hit the held-full error, then
        // release until the free-range store is full.
        write_register(pfa_pkg::CFG_POOL_START, '0);
        write_register(pfa_pkg::CFG_POOL_END, 23'h400000);
        for (int i = 0; i < NHELD / CMAX; i++)
            send_request(pfa_pkg::CMD_ALLOC, CW'(CMAX), slot);
        send_request(pfa_pkg::CMD_ALLOC, 7'd1, slot);
        for (int i = 0; i < NRANGES / CMAX + 1; i++)
            send_request(pfa_pkg::CMD_RELEASE, CW'(CMAX), slot);
        send_request(pfa_pkg::CMD_ALLOC, 7'd5, slot);

        // Random part: several pool settings, each followed by a mix of
        // requests. The register writes wait for every result to arrive.
        for (int ph = 0; ph < 6; ph++)
        begin
            lo = (PB+1)'($urandom_range(0, (1 << PB) - 1));
            case ($urandom_range(0, 2))
                0: pool_size = $urandom_range(0, 40);
                1: pool_size = $urandom_range(41, 5000);
                default: pool_size = 1 << (PB + 1);
            endcase
            if ($urandom_range(0, 1))
            begin
                write_register(pfa_pkg::CFG_POOL_END, (pool_size >= (1 << PB)) ? 23'h7FFFFF
                                             : lo + (PB+1)'(pool_size));
                write_register(pfa_pkg::CFG_POOL_START, lo);
            end
            else
            begin
                write_register(pfa_pkg::CFG_POOL_START, lo);
                write_register(pfa_pkg::CFG_POOL_END, (pool_size >= (1 << PB)) ? 23'h7FFFFF
                                             : lo + (PB+1)'(pool_size));
            end
            phase_items = $urandom_range(38, 48);
            for (int i = 0; i < phase_items; i++)
            begin
                if ($urandom_range(0, 99) < 68)
                    send_request(pfa_pkg::CMD_ALLOC, pick_alloc_count(), slot);
                else
                    send_request(pfa_pkg::CMD_RELEASE, CW'($urandom_range(0, 127)), slot);
                // Now and then the sender holds off until all results are in.
                if ($urandom_range(0, 29) == 0)
                begin
                    in_valid <= 1'b0;
                    burst_left = 0;
                    while (pending_grants.size() != 0)
                        @(posedge clk);
                end
            end
        end
        in_valid <= 1'b0;

        wait_until_drained();
        if (pending_grants.size() != 0)
            mismatches = mismatches + pending_grants.size();
        $display("Run covered %0d requests and %0d results over directed, stress and random pools.",
                 items_sent, grants_seen);
        $display("Results by status: ok %0d, few pages %0d, held full %0d, store full %0d.",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
        begin
            $display("%0d mismatches in total", mismatches);
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

[files.f]
+incdir+src
src/pfa_pkg.sv
src/pfa_ram.sv
src/page_frame_allocator_unit.sv
src/pfa_checker.sv
dv/page_frame_allocator_unit_tb.sv
